// ===== hdl/wsbd_pkg.sv =====
package wsbd_pkg;

	// Defaults for the top-level parameters.
	localparam int SAMPLE_BITS_DEF        = 10;
	localparam int WHEEL_COUNT_DEF        = 4;
	localparam int SLIP_FRACTION_BITS_DEF = 12;

	// Fixed field widths.
	localparam int THR_W   = 10;
	localparam int SLIP_W  = 16;
	localparam int SCALE_W = 16;
	localparam int DUTY_W  = 8;
	localparam int WSEL_W  = 2;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	// The wheel scale factor is Q2.14.
	localparam int SCALE_FRAC = 14;

	localparam logic [SLIP_W-1:0] SLIP_MAX = 16'hFFFF;

	// Register reset values.
	localparam logic [THR_W-1:0]   THR_RST   = 10'd511;
	localparam logic [SLIP_W-1:0]  DRY_RST   = 16'd1638;
	localparam logic [SLIP_W-1:0]  WET_RST   = 16'd573;
	localparam logic [SLIP_W-1:0]  BAND_RST  = 16'd410;
	localparam logic [DUTY_W-1:0]  BRAKE_RST = 8'd128;
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd16382;

	typedef enum logic [2:0] {
		REG_THRESHOLD = 3'd0,
		REG_DRY       = 3'd1,
		REG_WET       = 3'd2,
		REG_BAND      = 3'd3,
		REG_BRAKE     = 3'd4,
		REG_SCALE     = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIFF,
		ST_DIV,
		ST_DECIDE
	} state_t;

	// Status returned by the divider.
	typedef struct packed {
		logic done;
		logic sat;
	} div_stat_t;

endpackage

// ===== hdl/wsbd_div.sv =====
module wsbd_div #(
	parameter int SAMPLE_BITS        = wsbd_pkg::SAMPLE_BITS_DEF,
	parameter int SLIP_FRACTION_BITS = wsbd_pkg::SLIP_FRACTION_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [SAMPLE_BITS+wsbd_pkg::SCALE_W-1:0]    numer,
	input  logic [SAMPLE_BITS-1:0]                      vx,
	output logic [wsbd_pkg::SLIP_W-1:0]                 quotient,
	output wsbd_pkg::div_stat_t                         stat
);

	localparam int RW = SAMPLE_BITS + wsbd_pkg::SLIP_W;
	localparam int QW = wsbd_pkg::SLIP_W;
	localparam int SH = QW - SLIP_FRACTION_BITS;
	localparam int CW = $clog2(QW + 1);

	logic [RW-1:0] rem_q;
	logic [RW-1:0] rem_sh;
	logic [RW-1:0] dvs;
	logic [RW-1:0] cmp_a;
	logic [RW-1:0] dif;
	logic          ge;
	logic [QW-1:0] nlo_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          first_q;
	logic          done_q;
	logic          sat_q;

	// The divisor is the vehicle speed scaled to Q.14.
	assign dvs    = RW'({vx, {wsbd_pkg::SCALE_FRAC{1'b0}}});
	assign rem_sh = {rem_q[RW-2:0], nlo_q[QW-1]};

	// One shared compare and subtract. The first pass checks whether the
	// quotient would overflow the slip width; later passes make one bit each.
	assign cmp_a = first_q ? rem_q : rem_sh;
	assign ge    = (cmp_a >= dvs);
	assign dif   = cmp_a - dvs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
			end else if (busy_q) begin
				if (first_q) begin
					first_q <= 1'b0;
					if (ge) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(numer >> SH);
			nlo_q <= {numer[SH-1:0], {SLIP_FRACTION_BITS{1'b0}}};
			quo_q <= '0;
			cnt_q <= CW'(QW);
			sat_q <= 1'b0;
		end else if (busy_q) begin
			if (first_q) begin
				sat_q <= ge;
			end else begin
				rem_q <= ge ? dif : rem_sh;
				quo_q <= {quo_q[QW-2:0], ge};
				nlo_q <= {nlo_q[QW-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.done = done_q;
	assign stat.sat  = sat_q;

`ifndef NO_ASSERTIONS
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !first_q) |-> (cnt_q != '0))
		else $error("divider step counter ran out");
`endif

endmodule

// ===== hdl/wheel_slip_brake_decider_unit.sv =====
// Wheel slip brake decider.
// A sample beat carries the vehicle speed, one wheel's speed, a terrain level
// and the wheel number. The block forms the slip |vx - k*vw| / vx in Q4.12,
// compares it against the dry or wet target chosen by the terrain level, and
// returns one result beat with the slip, the duty now held for that wheel,
// the in-band flag, the sticky underslip lamp and the zero-speed flag.
// The user must write the registers over the APB-style port only while the
// block is idle; the block itself does not enforce this. A zero vehicle
// speed skips the divider; a quotient too large for the slip width is caught
// on the divider's first pass, which ends the divide early. The divider
// makes one quotient bit per cycle on a single shared compare and subtract.
// One sample is in work at a time, so no new sample is taken before the
// result is made, and sample_ready returns the cycle after the result is made.
// The finished result sits in an output register, so sample_ready returns as
// soon as the result is made. If the receiver stalls, a second result waits
// in the decision step until the register frees up; no beat is dropped.
// Reset loads the register defaults, zeroes every wheel's held duty and
// clears the underslip lamp.
module wheel_slip_brake_decider_unit #(
	parameter int SAMPLE_BITS        = wsbd_pkg::SAMPLE_BITS_DEF,
	parameter int WHEEL_COUNT        = wsbd_pkg::WHEEL_COUNT_DEF,
	parameter int SLIP_FRACTION_BITS = wsbd_pkg::SLIP_FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [wsbd_pkg::ADDR_W-1:0]        paddr,
	input  logic [wsbd_pkg::DATA_W-1:0]        pwdata,
	output logic [wsbd_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	// Sample channel.
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  logic [SAMPLE_BITS-1:0]             vehicle_speed,
	input  logic [SAMPLE_BITS-1:0]             wheel_speed,
	input  logic [SAMPLE_BITS-1:0]             terrain_level,
	input  logic [wsbd_pkg::WSEL_W-1:0]        wheel_select,
	// Result channel.
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [wsbd_pkg::WSEL_W-1:0]        wheel_index,
	output logic [wsbd_pkg::SLIP_W-1:0]        slip_ratio,
	output logic [wsbd_pkg::DUTY_W-1:0]        brake_duty,
	output logic                               within_band,
	output logic                               underslip_lamp,
	output logic                               speed_zero
);

	localparam int DW  = SAMPLE_BITS + wsbd_pkg::SCALE_W;
	localparam int TW  = (SAMPLE_BITS > wsbd_pkg::THR_W) ? SAMPLE_BITS : wsbd_pkg::THR_W;
	localparam int WIW = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
	localparam int SW  = wsbd_pkg::SLIP_W;
	localparam int DTW = wsbd_pkg::DUTY_W;

	// Configuration registers.
	logic [wsbd_pkg::THR_W-1:0]   thr_q;
	logic [SW-1:0]                dry_q;
	logic [SW-1:0]                wet_q;
	logic [SW-1:0]                band_q;
	logic [DTW-1:0]               brake_q;
	logic [wsbd_pkg::SCALE_W-1:0] scale_q;

	wsbd_pkg::reg_idx_t           reg_idx;
	logic                         cfg_wr;

	// Sample held for the duration of the work.
	logic [SAMPLE_BITS-1:0]       vx_q;
	logic [SAMPLE_BITS-1:0]       vw_q;
	logic [SAMPLE_BITS-1:0]       ter_q;
	logic [wsbd_pkg::WSEL_W-1:0]  wsel_q;
	logic [DW-1:0]                prod_q;
	logic [SW-1:0]                slip_q;

	// Per-wheel state.
	logic [DTW-1:0]               held_q [WHEEL_COUNT];
	logic                         lamp_q;

	// Sequencer.
	wsbd_pkg::state_t             state_q;
	wsbd_pkg::state_t             state_nx;
	logic                         accept;
	logic                         ld_prod;
	logic                         div_start;
	logic                         commit;

	// Arithmetic.
	logic [DW-1:0]                vxs;
	logic [DW-1:0]                diff;
	logic                         vx_zero;
	logic [SW-1:0]                quotient;
	wsbd_pkg::div_stat_t          div_stat;

	// Decision.
	logic [SW-1:0]                target;
	logic [SW-1:0]                err;
	logic                         band_ok;
	logic                         over;
	logic                         wvalid;
	logic [WIW-1:0]               widx;
	logic [DTW-1:0]               duty_nx;
	logic                         lamp_nx;

	// Result register.
	logic                         result_valid_q;
	logic [wsbd_pkg::WSEL_W-1:0]  wheel_index_q;
	logic [SW-1:0]                slip_ratio_q;
	logic [DTW-1:0]               brake_duty_q;
	logic                         within_band_q;
	logic                         underslip_lamp_q;
	logic                         speed_zero_q;

	// ------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is
	// tied high, so no access waits. Addresses past the last register are
	// ignored on write and read back as zero.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = wsbd_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= wsbd_pkg::THR_RST;
			dry_q   <= wsbd_pkg::DRY_RST;
			wet_q   <= wsbd_pkg::WET_RST;
			band_q  <= wsbd_pkg::BAND_RST;
			brake_q <= wsbd_pkg::BRAKE_RST;
			scale_q <= wsbd_pkg::SCALE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				wsbd_pkg::REG_THRESHOLD: thr_q   <= pwdata[wsbd_pkg::THR_W-1:0];
				wsbd_pkg::REG_DRY:       dry_q   <= pwdata[SW-1:0];
				wsbd_pkg::REG_WET:       wet_q   <= pwdata[SW-1:0];
				wsbd_pkg::REG_BAND:      band_q  <= pwdata[SW-1:0];
				wsbd_pkg::REG_BRAKE:     brake_q <= pwdata[DTW-1:0];
				wsbd_pkg::REG_SCALE:     scale_q <= pwdata[wsbd_pkg::SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			wsbd_pkg::REG_THRESHOLD: prdata = wsbd_pkg::DATA_W'(thr_q);
			wsbd_pkg::REG_DRY:       prdata = wsbd_pkg::DATA_W'(dry_q);
			wsbd_pkg::REG_WET:       prdata = wsbd_pkg::DATA_W'(wet_q);
			wsbd_pkg::REG_BAND:      prdata = wsbd_pkg::DATA_W'(band_q);
			wsbd_pkg::REG_BRAKE:     prdata = wsbd_pkg::DATA_W'(brake_q);
			wsbd_pkg::REG_SCALE:     prdata = wsbd_pkg::DATA_W'(scale_q);
			default:                 prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: capture, multiply, difference, divide (skipped for a zero vehicle speed), decide.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			wsbd_pkg::ST_IDLE:   if (sample_valid) state_nx = wsbd_pkg::ST_MUL;
			wsbd_pkg::ST_MUL:    state_nx = wsbd_pkg::ST_DIFF;
			wsbd_pkg::ST_DIFF:   state_nx = vx_zero ? wsbd_pkg::ST_DECIDE : wsbd_pkg::ST_DIV;
			wsbd_pkg::ST_DIV:    if (div_stat.done) state_nx = wsbd_pkg::ST_DECIDE;
			wsbd_pkg::ST_DECIDE: if (commit) state_nx = wsbd_pkg::ST_IDLE;
			default:             state_nx = wsbd_pkg::ST_IDLE;
		endcase
	end

	// The decision commits only when the result register is free or is
	// being emptied in the same cycle.
	always_comb begin
		sample_ready = 1'b0;
		ld_prod      = 1'b0;
		div_start    = 1'b0;
		commit       = 1'b0;
		unique case (state_q)
			wsbd_pkg::ST_IDLE:   sample_ready = 1'b1;
			wsbd_pkg::ST_MUL:    ld_prod = 1'b1;
			wsbd_pkg::ST_DIFF:   div_start = !vx_zero;
			wsbd_pkg::ST_DIV:    ;
			wsbd_pkg::ST_DECIDE: commit = !result_valid_q || result_ready;
			default:             ;
		endcase
	end

	assign accept = sample_valid && sample_ready;

	// ------------------------------------------------------------------
	// Datapath. The wheel product is kept exactly in Q.14 and compared with
	// the vehicle speed shifted to the same point.
	// ------------------------------------------------------------------
	assign vxs     = DW'({vx_q, {wsbd_pkg::SCALE_FRAC{1'b0}}});
	assign diff    = (vxs >= prod_q) ? (vxs - prod_q) : (prod_q - vxs);
	assign vx_zero = (vx_q == '0);

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q   <= vehicle_speed;
			vw_q   <= wheel_speed;
			ter_q  <= terrain_level;
			wsel_q <= wheel_select;
		end
		if (ld_prod) begin
			prod_q <= DW'(vw_q) * DW'(scale_q);
		end
		// A standing vehicle gives full-scale slip without dividing.
		if (state_q == wsbd_pkg::ST_DIFF && vx_zero) begin
			slip_q <= wsbd_pkg::SLIP_MAX;
		end else if (state_q == wsbd_pkg::ST_DIV && div_stat.done) begin
			slip_q <= div_stat.sat ? wsbd_pkg::SLIP_MAX : quotient;
		end
	end

	wsbd_div #(
		.SAMPLE_BITS        (SAMPLE_BITS),
		.SLIP_FRACTION_BITS (SLIP_FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (diff),
		.vx       (vx_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// ------------------------------------------------------------------
	// Decision. An error exactly on the band edge counts as inside. Out of
	// band, overslip loads the brake level into the wheel's held duty while
	// underslip latches the lamp and leaves the duty alone. A wheel number
	// past the wheel count stores nothing and reports zero duty.
	// ------------------------------------------------------------------
	assign target  = (TW'(ter_q) <= TW'(thr_q)) ? dry_q : wet_q;
	assign err     = (slip_q >= target) ? (slip_q - target) : (target - slip_q);
	assign band_ok = (err <= band_q);
	assign over    = (slip_q >= target);
	assign wvalid  = ({30'b0, wsel_q} < 32'(WHEEL_COUNT));
	assign widx    = WIW'(wsel_q);
	assign lamp_nx = lamp_q || (!band_ok && !over);

	always_comb begin
		duty_nx = '0;
		if (wvalid && !band_ok) begin
			duty_nx = over ? brake_q : held_q[widx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				held_q[i] <= '0;
			end
			lamp_q <= 1'b0;
		end else if (commit) begin
			if (wvalid) begin
				held_q[widx] <= duty_nx;
			end
			lamp_q <= lamp_nx;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (commit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			wheel_index_q    <= wsel_q;
			slip_ratio_q     <= slip_q;
			brake_duty_q     <= duty_nx;
			within_band_q    <= band_ok;
			underslip_lamp_q <= lamp_nx;
			speed_zero_q     <= vx_zero;
		end
	end

	assign result_valid   = result_valid_q;
	assign wheel_index    = wheel_index_q;
	assign slip_ratio     = slip_ratio_q;
	assign brake_duty     = brake_duty_q;
	assign within_band    = within_band_q;
	assign underslip_lamp = underslip_lamp_q;
	assign speed_zero     = speed_zero_q;

`ifndef NO_ASSERTIONS
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == wsbd_pkg::ST_DIV))
		else $error("divider finished outside the divide step");
	a_zero_speed_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && speed_zero) |-> (slip_ratio == wsbd_pkg::SLIP_MAX))
		else $error("zero vehicle speed without saturated slip");
	a_band_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && within_band) |-> (brake_duty == '0))
		else $error("in-band result with nonzero brake duty");
	a_lamp_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		lamp_q |=> lamp_q)
		else $error("underslip lamp cleared without reset");
`endif

endmodule
